/* design/bir_pkg.sv */
// ----------------------------------------------------------------------------
// bir_pkg
// Shared types and constants of the bilinear image rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package bir_pkg;

    localparam int MaxRows   = 128;
    localparam int MaxCols   = 128;
    localparam int FracBits  = 14;
    localparam int TrigBits  = 14;
    localparam int RowW      = $clog2(MaxRows);
    localparam int ColW      = $clog2(MaxCols);
    localparam int BankDepth = (MaxRows / 2) * (MaxCols / 2);
    localparam int BankAw    = $clog2(BankDepth);
    // a mapped coordinate: integer part plus fraction, signed, with headroom
    localparam int CoordW    = RowW + ColW + FracBits + 4;

    localparam logic [1:0] RegRows = 2'd0;
    localparam logic [1:0] RegCols = 2'd1;
    localparam logic [1:0] RegCos  = 2'd2;
    localparam logic [1:0] RegSin  = 2'd3;

    localparam logic CmdWrite   = 1'b0;
    localparam logic CmdRequest = 1'b1;

    // item passed from front to back, a pixel write or a mapped request
    typedef struct packed {
        logic                cmd;
        logic [31:0]         wdata;
        logic [RowW-1:0]     row;
        logic [ColW-1:0]     col;
        logic                in_src;
        logic [RowW-1:0]     r0;
        logic [ColW-1:0]     c0;
        logic [FracBits-1:0] fr;
        logic [FracBits-1:0] fc;
    } t_req;

    typedef struct packed {
        logic [RowW-1:0] row;
        logic [ColW-1:0] col;
        logic [7:0]      red;
        logic [7:0]      green;
        logic [7:0]      blue;
        logic [7:0]      alpha;
        logic            in_src;
    } t_res;

endpackage

`default_nettype wire

/* design/bilinear_image_rotator.sv */
// ----------------------------------------------------------------------------
// bilinear_image_rotator
// Rotates an RGBA image about its centre with bilinear interpolation.
//
//   channel  direction  handshake            payload
//   in       input      i_valid / o_stall    cmd, pix_row, pix_col, rgba
//   out      output     o_valid / i_stall    out_row, out_col, rgba, inside
//   cfg      input      i_cfg_we             i_cfg_index, i_cfg_data
//
// One item per cycle sustained while the output is not stalled. A request
// passes six registers: two mapping stages, the queue, the banked store
// read, the row blend and the column blend into the output register.
// Writes take the same path and land in one of four parity banks at the
// read stage, so they stay in order with requests.
// Reset is synchronous; it clears control and loads the default configuration;
// the store is undefined. Stalls back up through the queue; the front stalls
// only when it is full.
`default_nettype none

module bilinear_image_rotator (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic                     i_cmd,
    input  wire logic [bir_pkg::RowW-1:0] i_pix_row,
    input  wire logic [bir_pkg::ColW-1:0] i_pix_col,
    input  wire logic [7:0]               i_in_red,
    input  wire logic [7:0]               i_in_green,
    input  wire logic [7:0]               i_in_blue,
    input  wire logic [7:0]               i_in_alpha,
    input  wire logic                     i_cfg_we,
    input  wire logic [1:0]               i_cfg_index,
    input  wire logic [15:0]              i_cfg_data,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [bir_pkg::RowW-1:0]      o_out_row,
    output logic [bir_pkg::ColW-1:0]      o_out_col,
    output logic [7:0]                    o_out_red,
    output logic [7:0]                    o_out_green,
    output logic [7:0]                    o_out_blue,
    output logic [7:0]                    o_out_alpha,
    output logic                          o_inside_source
);
    import bir_pkg::*;

    logic [7:0]         r_rows, r_cols;
    logic signed [15:0] r_cos, r_sin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 8'(MaxRows);
            r_cols <= 8'(MaxCols);
            r_cos  <= 16'sd16384;
            r_sin  <= 16'sd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                RegRows: r_rows <= i_cfg_data[7:0];
                RegCols: r_cols <= i_cfg_data[7:0];
                RegCos:  r_cos  <= i_cfg_data;
                RegSin:  r_sin  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic f_stall, f_valid, q_stall, q_valid, b_stall;
    t_req f_req, q_req;
    t_res b_res;

    assign o_stall = f_stall;

    bir_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(f_stall),
        .i_cmd  (i_cmd),
        .i_wdata({i_in_alpha, i_in_blue, i_in_green, i_in_red}),
        .i_row  (i_pix_row),
        .i_col  (i_pix_col),
        .i_rows (r_rows),
        .i_cols (r_cols),
        .i_cos  (r_cos),
        .i_sin  (r_sin),
        .o_valid(f_valid),
        .i_stall(q_stall),
        .o_req  (f_req)
    );

    bir_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(f_valid),
        .o_stall(q_stall),
        .i_req  (f_req),
        .o_valid(q_valid),
        .i_stall(b_stall),
        .o_req  (q_req)
    );

    bir_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .o_stall(b_stall),
        .i_req  (q_req),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_res  (b_res)
    );

    assign o_out_row       = b_res.row;
    assign o_out_col       = b_res.col;
    assign o_out_red       = b_res.red;
    assign o_out_green     = b_res.green;
    assign o_out_blue      = b_res.blue;
    assign o_out_alpha     = b_res.alpha;
    assign o_inside_source = b_res.in_src;

endmodule

`default_nettype wire

/* design/bir_ram.sv */
// ----------------------------------------------------------------------------
// bir_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bir_ram #(
    parameter int Width = 32,
    parameter int Depth = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* design/bir_front.sv */
// ----------------------------------------------------------------------------
// bir_front
// Maps a requested position back into the source image, two stages:
// products, then sums, floor and inside test.
// ----------------------------------------------------------------------------
`default_nettype none

module bir_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic                      i_cmd,
    input  wire logic [31:0]               i_wdata,
    input  wire logic [bir_pkg::RowW-1:0]  i_row,
    input  wire logic [bir_pkg::ColW-1:0]  i_col,
    input  wire logic [7:0]                i_rows,
    input  wire logic [7:0]                i_cols,
    input  wire logic signed [15:0]        i_cos,
    input  wire logic signed [15:0]        i_sin,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output bir_pkg::t_req                  o_req
);
    import bir_pkg::*;

    localparam int DW = RowW + FracBits + 2;   // signed offset from centre
    localparam int PW = DW + 16;

    logic [RowW:0] w_rows;
    logic [ColW:0] w_cols;
    logic signed [DW-1:0] w_dr, w_dc;

    logic                 r_v1, r_v2;
    logic                 r_cmd1;
    logic [31:0]          r_wdata1;
    logic [RowW-1:0]      r_row1;
    logic [ColW-1:0]      r_col1;
    logic [RowW:0]        r_rows1;
    logic [ColW:0]        r_cols1;
    logic signed [PW-1:0] r_rc, r_cs, r_cc, r_rs;
    t_req                 r_req;

    logic signed [PW:0]     w_sr, w_sc;
    logic signed [CoordW-1:0] w_xr, w_xc, w_cr, w_cc, w_lr, w_lc;
    logic                   w_in;
    logic                   w_adv2, w_adv1;

    always_comb begin
        // saturate dimensions to 1..max
        if (i_rows == 8'd0) w_rows = (RowW+1)'(1);
        else if (32'(i_rows) > MaxRows) w_rows = (RowW+1)'(MaxRows);
        else w_rows = (RowW+1)'(i_rows);
        if (i_cols == 8'd0) w_cols = (ColW+1)'(1);
        else if (32'(i_cols) > MaxCols) w_cols = (ColW+1)'(MaxCols);
        else w_cols = (ColW+1)'(i_cols);
        w_dr = $signed({2'b00, i_row, {FracBits{1'b0}}})
             - $signed(DW'({w_rows, {(FracBits-1){1'b0}}}));
        w_dc = $signed({2'b00, i_col, {FracBits{1'b0}}})
             - $signed(DW'({w_cols, {(FracBits-1){1'b0}}}));
    end

    assign w_adv2 = !r_v2 || !i_stall;
    assign w_adv1 = !r_v1 || w_adv2;
    assign o_stall = !w_adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_adv1) begin
            r_v1 <= i_valid;
        end
        if (w_adv1 && i_valid) begin
            r_cmd1   <= i_cmd;
            r_wdata1 <= i_wdata;
            r_row1   <= i_row;
            r_col1   <= i_col;
            r_rows1  <= w_rows;
            r_cols1  <= w_cols;
            r_rc     <= PW'(w_dr * i_cos);
            r_cs     <= PW'(w_dc * i_sin);
            r_cc     <= PW'(w_dc * i_cos);
            r_rs     <= PW'(w_dr * i_sin);
        end
    end

    always_comb begin
        w_sr = (PW+1)'(r_rc) + (PW+1)'(r_cs);
        w_sc = (PW+1)'(r_cc) - (PW+1)'(r_rs);
        w_cr = CoordW'({r_rows1, {(FracBits-1){1'b0}}});
        w_cc = CoordW'({r_cols1, {(FracBits-1){1'b0}}});
        // arithmetic shift gives floor
        w_xr = CoordW'(w_sr >>> TrigBits) + w_cr;
        w_xc = CoordW'(w_sc >>> TrigBits) + w_cc;
        w_lr = CoordW'({r_rows1 - (RowW+1)'(1), {FracBits{1'b0}}});
        w_lc = CoordW'({r_cols1 - (ColW+1)'(1), {FracBits{1'b0}}});
        w_in = !w_xr[CoordW-1] && !w_xc[CoordW-1] && (w_xr < w_lr) && (w_xc < w_lc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_adv2) begin
            r_v2 <= r_v1;
        end
        if (w_adv2 && r_v1) begin
            r_req.cmd    <= r_cmd1;
            r_req.wdata  <= r_wdata1;
            r_req.row    <= r_row1;
            r_req.col    <= r_col1;
            r_req.in_src <= w_in;
            r_req.r0     <= w_xr[FracBits +: RowW];
            r_req.c0     <= w_xc[FracBits +: ColW];
            r_req.fr     <= w_xr[FracBits-1:0];
            r_req.fc     <= w_xc[FracBits-1:0];
        end
    end

    assign o_valid = r_v2;
    assign o_req   = r_req;

endmodule

`default_nettype wire

/* design/bir_queue.sv */
// ----------------------------------------------------------------------------
// bir_queue
// Two-entry queue between the mapping front and the blending back.
// ----------------------------------------------------------------------------
`default_nettype none

module bir_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire bir_pkg::t_req  i_req,
    output logic                o_valid,
    input  wire logic           i_stall,
    output bir_pkg::t_req       o_req
);
    import bir_pkg::*;

    t_req       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_q[r_rp];
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
        if (w_push) r_q[r_wp] <= i_req;
    end

endmodule

`default_nettype wire

/* design/bir_back.sv */
// ----------------------------------------------------------------------------
// bir_back
// Parity-banked frame store, four neighbour reads and the bilinear blend.
// Writes land in the store here, in order with requests.
// Stages: read, row blend, column blend into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bir_back (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire bir_pkg::t_req            i_req,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output bir_pkg::t_res                 o_res
);
    import bir_pkg::*;

    localparam int AW = FracBits + 10;        // signed row blend
    localparam int VW = 2 * FracBits + 11;    // signed final blend

    logic w_a0, w_a1, w_a2, w_a3;
    logic w_take, w_wr, w_rd;
    logic r_v1, r_v2, r_v3;
    t_req r_q1, r_q2;
    logic [31:0] w_rd_data [4];
    logic [31:0] w_p00, w_p10, w_p01, w_p11;
    logic signed [AW-1:0] r_a [4];
    logic signed [AW-1:0] r_b [4];
    t_res r_res;

    assign w_a3 = !r_v3 || !i_stall;
    assign w_a2 = !r_v2 || w_a3;
    assign w_a1 = !r_v1 || w_a2;
    assign w_a0 = w_a1;
    assign o_stall = !w_a0;

    assign w_take = w_a1 && i_valid;
    assign w_wr   = w_take && (i_req.cmd == CmdWrite);
    assign w_rd   = w_take && (i_req.cmd == CmdRequest);

    // bank = {row parity, col parity}
    logic [RowW-1:0] w_re, w_ro;
    logic [ColW-1:0] w_ce, w_co;
    always_comb begin
        w_ro = i_req.r0[0] ? i_req.r0 : i_req.r0 + RowW'(1);
        w_re = i_req.r0[0] ? i_req.r0 + RowW'(1) : i_req.r0;
        w_co = i_req.c0[0] ? i_req.c0 : i_req.c0 + ColW'(1);
        w_ce = i_req.c0[0] ? i_req.c0 + ColW'(1) : i_req.c0;
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [RowW-1:0] w_r;
        logic [ColW-1:0] w_c;
        assign w_r = b[1] ? w_ro : w_re;
        assign w_c = b[0] ? w_co : w_ce;
        bir_ram #(.Width(32), .Depth(BankDepth)) u_ram (
            .i_clk  (i_clk),
            .i_we   (w_wr && (i_req.row[0] == b[1]) && (i_req.col[0] == b[0])),
            .i_waddr({i_req.row[RowW-1:1], i_req.col[ColW-1:1]}),
            .i_wdata(i_req.wdata),
            .i_re   (w_rd),
            .i_raddr({w_r[RowW-1:1], w_c[ColW-1:1]}),
            .o_rdata(w_rd_data[b])
        );
    end

    always_comb begin
        w_p00 = w_rd_data[{r_q1.r0[0], r_q1.c0[0]}];
        w_p10 = w_rd_data[{!r_q1.r0[0], r_q1.c0[0]}];
        w_p01 = w_rd_data[{r_q1.r0[0], !r_q1.c0[0]}];
        w_p11 = w_rd_data[{!r_q1.r0[0], !r_q1.c0[0]}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            // a write item ends at the store
            if (w_a1) r_v1 <= i_valid && (i_req.cmd == CmdRequest);
            if (w_a2) r_v2 <= r_v1;
            if (w_a3) r_v3 <= r_v2;
        end
        if (w_take) r_q1 <= i_req;
        if (w_a2 && r_v1) begin
            r_q2 <= r_q1;
            for (int k = 0; k < 4; k++) begin
                r_a[k] <= AW'($signed({1'b0, w_p00[8*k +: 8], {FracBits{1'b0}}}))
                    + AW'($signed({1'b0, r_q1.fr})
                        * ($signed({1'b0, w_p10[8*k +: 8]}) - $signed({1'b0, w_p00[8*k +: 8]})));
                r_b[k] <= AW'($signed({1'b0, w_p01[8*k +: 8], {FracBits{1'b0}}}))
                    + AW'($signed({1'b0, r_q1.fr})
                        * ($signed({1'b0, w_p11[8*k +: 8]}) - $signed({1'b0, w_p01[8*k +: 8]})));
            end
        end
    end

    logic signed [VW-1:0] w_v [4];
    logic [7:0] w_ch [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_v[k] = (VW'(r_a[k]) <<< FracBits)
                   + VW'($signed({1'b0, r_q2.fc}) * (r_b[k] - r_a[k]));
            w_ch[k] = w_v[k][2*FracBits +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a3 && r_v2) begin
            r_res.row    <= r_q2.row;
            r_res.col    <= r_q2.col;
            r_res.in_src <= r_q2.in_src;
            r_res.red    <= r_q2.in_src ? w_ch[0] : 8'd0;
            r_res.green  <= r_q2.in_src ? w_ch[1] : 8'd0;
            r_res.blue   <= r_q2.in_src ? w_ch[2] : 8'd0;
            r_res.alpha  <= r_q2.in_src ? w_ch[3] : 8'd255;
        end
    end

    assign o_valid = r_v3;
    assign o_res   = r_res;

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bilinear image rotator. Source pixels are
// written into the frame store and rotated pixels are requested. A local
// model of the rotation and bilinear blend predicts each result, and every
// result is compared field by field. The sender and the receiver idle in
// several phases, and a long receiver hold-off fills the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bir_pkg::*;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_stall;
    logic            i_cmd;
    logic [RowW-1:0] i_pix_row;
    logic [ColW-1:0] i_pix_col;
    logic [7:0]      i_in_red;
    logic [7:0]      i_in_green;
    logic [7:0]      i_in_blue;
    logic [7:0]      i_in_alpha;
    logic            i_cfg_we;
    logic [1:0]      i_cfg_index;
    logic [15:0]     i_cfg_data;
    logic            o_valid;
    logic            i_stall;
    logic [RowW-1:0] o_out_row;
    logic [ColW-1:0] o_out_col;
    logic [7:0]      o_out_red;
    logic [7:0]      o_out_green;
    logic [7:0]      o_out_blue;
    logic [7:0]      o_out_alpha;
    logic            o_inside_source;

    bilinear_image_rotator DUT (.*);

    // model state
    logic [31:0]        src_pixels [MaxRows*MaxCols];
    bit                 src_written [MaxRows*MaxCols];
    logic [7:0]         cfg_rows, cfg_cols;
    logic signed [15:0] cfg_cos, cfg_sin;

    t_res pending_pixels [$];
    int   mismatches;
    int   n_writes, n_requests, n_results;
    int   send_idle_pct, stall_pct;
    int   hold_request, hold_left;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: random stalls, or a counted hold-off when asked
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (pending_pixels.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result row %0d col %0d", $time,
                         o_out_row, o_out_col);
            end else begin
                want = pending_pixels.pop_front();
                if (o_out_row !== want.row || o_out_col !== want.col ||
                    o_out_red !== want.red || o_out_green !== want.green ||
                    o_out_blue !== want.blue || o_out_alpha !== want.alpha ||
                    o_inside_source !== want.in_src) begin
                    mismatches++;
                    $display("%0t: expected pos %0d,%0d rgba %h %h %h %h in %b",
                             $time, want.row, want.col, want.red, want.green,
                             want.blue, want.alpha, want.in_src);
                    $display("%0t:   actual pos %0d,%0d rgba %h %h %h %h in %b",
                             $time, o_out_row, o_out_col, o_out_red, o_out_green,
                             o_out_blue, o_out_alpha, o_inside_source);
                end
            end
        end
    end

    function automatic int eff_dim(logic [7:0] v, int maxv);
        if (v < 1) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // map an output position back into the source, Q.14 coordinates
    function automatic bit map_back(int row, int col, output int r0, output int c0,
                                    output longint fr, output longint fc);
        longint rows, cols, cr, cc, dr, dc, xr, xc;
        rows = eff_dim(cfg_rows, MaxRows);
        cols = eff_dim(cfg_cols, MaxCols);
        cr = rows * (1 << (FracBits - 1));
        cc = cols * (1 << (FracBits - 1));
        dr = longint'(row) * (1 << FracBits) - cr;
        dc = longint'(col) * (1 << FracBits) - cc;
        xr = ((dr * cfg_cos + dc * cfg_sin) >>> TrigBits) + cr;
        xc = ((dc * cfg_cos - dr * cfg_sin) >>> TrigBits) + cc;
        r0 = int'(xr >>> FracBits);
        c0 = int'(xc >>> FracBits);
        fr = xr & ((1 << FracBits) - 1);
        fc = xc & ((1 << FracBits) - 1);
        return xr >= 0 && xr < (rows - 1) * (1 << FracBits) &&
               xc >= 0 && xc < (cols - 1) * (1 << FracBits);
    endfunction

    function automatic logic [7:0] blend_channel(int sh, int r0, int c0,
                                                 longint fr, longint fc);
        longint v00, v10, v01, v11, a, b, v;
        v00 = (src_pixels[r0*MaxCols + c0] >> sh) & 8'hff;
        v10 = (src_pixels[(r0+1)*MaxCols + c0] >> sh) & 8'hff;
        v01 = (src_pixels[r0*MaxCols + c0 + 1] >> sh) & 8'hff;
        v11 = (src_pixels[(r0+1)*MaxCols + c0 + 1] >> sh) & 8'hff;
        a = v00 * (1 << FracBits) + fr * (v10 - v00);
        b = v01 * (1 << FracBits) + fr * (v11 - v01);
        v = a * (1 << FracBits) + fc * (b - a);
        return 8'((v >>> (2 * FracBits)) & 8'hff);
    endfunction

    function automatic t_res predict_pixel(int row, int col);
        t_res   r;
        int     r0, c0;
        longint fr, fc;
        r.row = RowW'(row);
        r.col = ColW'(col);
        r.in_src = map_back(row, col, r0, c0, fr, fc);
        if (r.in_src) begin
            r.red   = blend_channel(0, r0, c0, fr, fc);
            r.green = blend_channel(8, r0, c0, fr, fc);
            r.blue  = blend_channel(16, r0, c0, fr, fc);
            r.alpha = blend_channel(24, r0, c0, fr, fc);
        end else begin
            r.red = 8'd0;
            r.green = 8'd0;
            r.blue = 8'd0;
            r.alpha = 8'd255;
        end
        return r;
    endfunction

    task automatic send_item(logic cmd, int row, int col, logic [31:0] rgba);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cmd      <= cmd;
        i_pix_row  <= RowW'(row);
        i_pix_col  <= ColW'(col);
        i_in_red   <= rgba[7:0];
        i_in_green <= rgba[15:8];
        i_in_blue  <= rgba[23:16];
        i_in_alpha <= rgba[31:24];
        do @(posedge i_clk); while (o_stall);
        if (cmd == CmdWrite) begin
            src_pixels[row*MaxCols + col] = rgba;
            src_written[row*MaxCols + col] = 1'b1;
            n_writes++;
        end else begin
            pending_pixels.push_back(predict_pixel(row, col));
            n_requests++;
        end
    endtask

    task automatic write_pixel(int row, int col);
        send_item(CmdWrite, row, col, $urandom());
    endtask

    // never blend an unwritten store entry: fill missing neighbours first
    task automatic request_pixel(int row, int col);
        int     r0, c0;
        longint fr, fc;
        if (map_back(row, col, r0, c0, fr, fc)) begin
            for (int dr = 0; dr < 2; dr++)
                for (int dc = 0; dc < 2; dc++)
                    if (!src_written[(r0+dr)*MaxCols + c0 + dc])
                        write_pixel(r0 + dr, c0 + dc);
        end
        send_item(CmdRequest, row, col, $urandom());
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_config(int rows, int cols, int cosv, int sinv);
        drain_results();
        i_cfg_we <= 1'b1; i_cfg_index <= RegRows; i_cfg_data <= 16'(rows);
        @(posedge i_clk);
        cfg_rows = 8'(rows);
        i_cfg_index <= RegCols; i_cfg_data <= 16'(cols);
        @(posedge i_clk);
        cfg_cols = 8'(cols);
        i_cfg_index <= RegCos; i_cfg_data <= 16'(cosv);
        @(posedge i_clk);
        cfg_cos = 16'(cosv);
        i_cfg_index <= RegSin; i_cfg_data <= 16'(sinv);
        @(posedge i_clk);
        cfg_sin = 16'(sinv);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct = 0;
        // identity at reset settings, corner pixels and extreme bytes
        send_item(CmdWrite, 0, 0, 32'h00000000);
        send_item(CmdWrite, 0, 1, 32'hffffffff);
        send_item(CmdWrite, 1, 0, 32'hff00ff00);
        send_item(CmdWrite, 1, 1, 32'h00ff00ff);
        request_pixel(0, 0);
        request_pixel(127, 127);
        request_pixel(64, 64);
        set_config(128, 128, 0, 16384);       // quarter turn
        request_pixel(10, 100);
        request_pixel(127, 0);
        set_config(128, 128, -16384, 0);      // half turn
        request_pixel(64, 64);
        request_pixel(1, 1);
        set_config(128, 128, 0, -16384);
        request_pixel(100, 3);
        set_config(1, 128, 16384, 0);         // single row: nothing inside
        request_pixel(0, 5);
        set_config(128, 1, 16384, 0);         // single column
        request_pixel(5, 0);
        set_config(0, 255, 16384, 0);         // saturated dimensions
        request_pixel(0, 60);
        set_config(8, 8, 11585, 11585);       // request outside the image
        request_pixel(120, 120);
        request_pixel(3, 4);
        set_config(16, 16, 16384, 16384);     // beyond unit magnitude
        request_pixel(7, 9);
        request_pixel(2, 13);
    endtask

    // count is the least number of items sent, neighbour fills included
    task automatic test_random_phase(int idle_pct, int stall, int count);
        int rows, cols, big, start;
        big = ($urandom_range(3) == 0);
        rows = big ? $urandom_range(64, 128) : $urandom_range(2, 24);
        cols = big ? $urandom_range(64, 128) : $urandom_range(2, 24);
        set_config(rows, cols, $urandom_range(32768) - 16384,
                   $urandom_range(32768) - 16384);
        send_idle_pct = idle_pct;
        stall_pct = stall;
        start = n_writes + n_requests;
        while (n_writes + n_requests - start < count) begin
            if ($urandom_range(2) == 0)
                write_pixel($urandom_range(127), $urandom_range(127));
            else if ($urandom_range(9) == 0)
                request_pixel($urandom_range(127), $urandom_range(127));
            else
                request_pixel($urandom_range(rows - 1), $urandom_range(cols - 1));
        end
    endtask

    task automatic test_backpressure();
        set_config(32, 32, 14189, 8192);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_request = 300;
        for (int n = 0; n < 80; n++)
            request_pixel($urandom_range(31), $urandom_range(31));
        // sender pauses until every result is back
        drain_results();
        for (int n = 0; n < 20; n++)
            request_pixel($urandom_range(31), $urandom_range(31));
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cmd = CmdWrite;
        i_pix_row = '0;
        i_pix_col = '0;
        i_in_red = '0;
        i_in_green = '0;
        i_in_blue = '0;
        i_in_alpha = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = RegRows;
        i_cfg_data = '0;
        i_stall = 1'b0;
        hold_request = 0;
        hold_left = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        mismatches = 0;
        cfg_rows = 8'd128;
        cfg_cols = 8'd128;
        cfg_cos = 16'sd16384;
        cfg_sin = 16'sd0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        for (int k = 0; k < 2; k++) begin
            test_random_phase(0, 0, 180);
            test_random_phase(80, 0, 170);
            test_random_phase(0, 80, 170);
            test_random_phase(20, 20, 170);
        end
        test_backpressure();

        drain_results();
        $display("covered %0d pixel writes and %0d requests (%0d results)",
                 n_writes, n_requests, n_results);
        $display("configs with rotation, saturation, thin images and stalls");
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
